FILE: hdl/go_to_goal_p_controller_assert.svh
// Assertion macros for the go-to-goal controller.
// Used by the top level only; compiled empty when SYNTHESIS is defined.
`ifndef GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define GGPC_ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define GGPC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define GGPC_ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define GGPC_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

FILE: hdl/ggpc_pkg.sv
// Package for the go-to-goal controller: widths, constants, the lane type
// and the arctangent table. No dependencies.
`default_nettype none
package ggpc_pkg;
  localparam int POS_WIDTH    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int DIFF_W       = POS_WIDTH + 1;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int SQRT_DIGITS  = SQ_W / 2;
  localparam int NCELL        = (SQRT_DIGITS > CORDIC_STEPS) ? SQRT_DIGITS : CORDIC_STEPS;
  localparam int STAGE_W      = $clog2(NCELL);
  localparam int XY_W         = DIFF_W + 14 + 2;
  localparam int Z_W          = 21;
  localparam int BRG_W        = Z_W - 4;
  localparam int ERR_W        = 18;

  localparam logic signed [Z_W-1:0] PI_Q16     = Z_W'(205887);
  localparam logic signed [ERR_W-1:0] WRAP_LIMIT = ERR_W'(12861);
  localparam logic signed [ERR_W-1:0] WRAP_STEP  = ERR_W'(25723);
  localparam logic [20:0] LIN_MAX = 21'h1FFFFF;

  localparam logic [2:0] REG_GOAL_X       = 3'd0;
  localparam logic [2:0] REG_GOAL_Y       = 3'd1;
  localparam logic [2:0] REG_LINEAR_GAIN  = 3'd2;
  localparam logic [2:0] REG_ANGULAR_GAIN = 3'd3;
  localparam logic [2:0] REG_HOLD_TICKS   = 3'd4;

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic                    hold;
    logic signed [14:0]      heading;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic [SQ_W-1:0]         n;
    logic [SQ_W-1:0]         r;
  } lane_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STAGE_W-1:0] s);
    logic signed [Z_W-1:0] v;
    case (s)
      0: v = Z_W'(51472);
      1: v = Z_W'(30386);
      2: v = Z_W'(16055);
      3: v = Z_W'(8150);
      4: v = Z_W'(4091);
      5: v = Z_W'(2047);
      6: v = Z_W'(1024);
      7: v = Z_W'(512);
      8: v = Z_W'(256);
      9: v = Z_W'(128);
      10: v = Z_W'(64);
      11: v = Z_W'(32);
      12: v = Z_W'(16);
      13: v = Z_W'(8);
      14: v = Z_W'(4);
      15: v = Z_W'(2);
      16: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/ggpc_cell.sv
// One cell of the chain: one CORDIC vectoring step (for stages below CORDIC_STEPS) and one square root digit.
// Depends on ggpc_pkg.
`default_nettype none
module ggpc_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ggpc_pkg::STAGE_W-1:0] stage_i,
  input  wire ggpc_pkg::lane_t              lane_i,
  output ggpc_pkg::lane_t                   lane_o
);
  ggpc_pkg::lane_t lane_d, lane_q;
  logic signed [ggpc_pkg::XY_W-1:0] xs, ys;
  logic [ggpc_pkg::SQ_W-1:0] bitv, trial;

  always_comb begin
    lane_d = lane_i;
    xs = lane_i.x >>> stage_i;
    ys = lane_i.y >>> stage_i;
    bitv = ggpc_pkg::SQ_W'(1) << (2 * (ggpc_pkg::SQRT_DIGITS - 1 - int'(stage_i)));
    trial = lane_i.r + bitv;
    if (int'(stage_i) < ggpc_pkg::CORDIC_STEPS) begin
      if (!lane_i.y[ggpc_pkg::XY_W-1]) begin
        lane_d.x = lane_i.x + ys;
        lane_d.y = lane_i.y - xs;
        lane_d.z = lane_i.z + ggpc_pkg::atan_q16(stage_i);
      end else begin
        lane_d.x = lane_i.x - ys;
        lane_d.y = lane_i.y + xs;
        lane_d.z = lane_i.z - ggpc_pkg::atan_q16(stage_i);
      end
    end
    if (int'(stage_i) < ggpc_pkg::SQRT_DIGITS) begin
      if (lane_i.n >= trial) begin
        lane_d.n = lane_i.n - trial;
        lane_d.r = (lane_i.r >> 1) + bitv;
      end else begin
        lane_d.r = lane_i.r >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;
endmodule
`default_nettype wire

FILE: hdl/go_to_goal_p_controller.sv
// Go-to-goal proportional controller: pose in, velocity command out.
// Path: the preset register loads at the accepting edge, then
// ggpc_pkg::NCELL chain cells and one output stage follow.
// The cell chain holds one item at a time: no new pose is taken
// until the last one has reached the output register. Reset clears
// control state and config to defaults.
`default_nettype none
`include "go_to_goal_p_controller_assert.svh"
module go_to_goal_p_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic signed [14:0] heading_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [20:0]      linear_vel_o,
  output logic signed [18:0] angular_vel_o,
  output logic signed [14:0] heading_error_o
);
  // Configuration registers.
  logic signed [15:0] goal_x_q, goal_y_q;
  logic [11:0] lin_gain_q, ang_gain_q;
  logic [15:0] hold_ticks_q, tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      lin_gain_q   <= 12'd128;
      ang_gain_q   <= 12'd512;
      hold_ticks_q <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ggpc_pkg::REG_GOAL_X:       goal_x_q     <= cfg_wdata_i;
        ggpc_pkg::REG_GOAL_Y:       goal_y_q     <= cfg_wdata_i;
        ggpc_pkg::REG_LINEAR_GAIN:  lin_gain_q   <= cfg_wdata_i[11:0];
        ggpc_pkg::REG_ANGULAR_GAIN: ang_gain_q   <= cfg_wdata_i[11:0];
        ggpc_pkg::REG_HOLD_TICKS:   hold_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The block takes a pose only when the chain is empty and the output
  // register is free, so a finished result always finds room.
  logic busy_q, out_valid_q, accept, load_out;
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;

  // Preset stage: differences, sum of squares and the CORDIC start vector.
  logic signed [ggpc_pkg::DIFF_W-1:0] dx, dy;
  logic [ggpc_pkg::DIFF_W-1:0] ax, ay;
  ggpc_pkg::lane_t pre_d, pre_q;
  logic hold_now;

  always_comb begin
    dx = ggpc_pkg::DIFF_W'(goal_x_q) - ggpc_pkg::DIFF_W'(pos_x_i);
    dy = ggpc_pkg::DIFF_W'(goal_y_q) - ggpc_pkg::DIFF_W'(pos_y_i);
    ax = dx[ggpc_pkg::DIFF_W-1] ? ggpc_pkg::DIFF_W'(-dx) : ggpc_pkg::DIFF_W'(dx);
    ay = dy[ggpc_pkg::DIFF_W-1] ? ggpc_pkg::DIFF_W'(-dy) : ggpc_pkg::DIFF_W'(dy);
    hold_now = tick_q < hold_ticks_q;
    pre_d.valid   = accept;
    pre_d.zero    = (dx == '0) && (dy == '0);
    pre_d.hold    = hold_now;
    pre_d.heading = heading_i;
    pre_d.n       = ggpc_pkg::SQ_W'(ax * ax) + ggpc_pkg::SQ_W'(ay * ay);
    pre_d.r       = '0;
    if (dx[ggpc_pkg::DIFF_W-1]) begin
      pre_d.x = -(ggpc_pkg::XY_W'(dx) <<< 14);
      pre_d.y = -(ggpc_pkg::XY_W'(dy) <<< 14);
      pre_d.z = dy[ggpc_pkg::DIFF_W-1] ? -ggpc_pkg::PI_Q16 : ggpc_pkg::PI_Q16;
    end else begin
      pre_d.x = ggpc_pkg::XY_W'(dx) <<< 14;
      pre_d.y = ggpc_pkg::XY_W'(dy) <<< 14;
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      tick_q <= '0;
    end else begin
      pre_q <= pre_d;
      if (accept && hold_now) begin
        tick_q <= tick_q + 16'd1;
      end
    end
  end

  // The chain: each cell does one root digit and, below CORDIC_STEPS, one rotation per cycle.
  ggpc_pkg::lane_t lanes [ggpc_pkg::NCELL+1];
  assign lanes[0] = pre_q;

  for (genvar k = 0; k < ggpc_pkg::NCELL; k++) begin : g_cell
    ggpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (ggpc_pkg::STAGE_W'(k)),
      .lane_i  (lanes[k]),
      .lane_o  (lanes[k+1])
    );
  end

  // Output stage: round the bearing, wrap the error, apply both gains, clamp the linear speed and zero it during hold.
  ggpc_pkg::lane_t fin;
  logic signed [ggpc_pkg::Z_W-1:0] zr;
  logic signed [ggpc_pkg::ERR_W-1:0] brg, err0, err;
  logic signed [31:0] ang_prod;
  logic [31:0] lin_prod;
  logic [20:0] lin_d;
  logic signed [18:0] ang_d;

  always_comb begin
    fin  = lanes[ggpc_pkg::NCELL];
    zr   = (fin.z + ggpc_pkg::Z_W'(8)) >>> 4;
    brg  = fin.zero ? '0 : ggpc_pkg::ERR_W'(zr);
    err0 = brg - ggpc_pkg::ERR_W'(fin.heading);
    if (err0 > ggpc_pkg::WRAP_LIMIT) begin
      err = err0 - ggpc_pkg::WRAP_STEP;
    end else if (err0 < -ggpc_pkg::WRAP_LIMIT) begin
      err = err0 + ggpc_pkg::WRAP_STEP;
    end else begin
      err = err0;
    end
    ang_prod = (32'(signed'({1'b0, ang_gain_q})) * 32'(err) + 32'sd128) >>> 8;
    ang_d    = ang_prod[18:0];
    lin_prod = ((32'(lin_gain_q) * 32'(fin.r[ggpc_pkg::SQRT_DIGITS:0])) + 32'd128) >> 8;
    if (fin.hold) begin
      lin_d = '0;
    end else if (lin_prod > 32'(ggpc_pkg::LIN_MAX)) begin
      lin_d = ggpc_pkg::LIN_MAX;
    end else begin
      lin_d = lin_prod[20:0];
    end
  end

  assign load_out = fin.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      linear_vel_o    <= lin_d;
      angular_vel_o   <= ang_d;
      heading_error_o <= err[14:0];
    end
  end

  assign out_valid_o = out_valid_q;

  `GGPC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_q)
  `GGPC_ASSERT_IMPLIES(a_no_ready_busy, clk_i, rst_ni, busy_q, !in_ready_o)
  `GGPC_ASSERT_IMPLIES(a_load_busy, clk_i, rst_ni, load_out, busy_q && !out_valid_q)
endmodule
`default_nettype wire
